@@ hdl/dwsa_pkg.sv @@
// Shared constants for the DMA write segmented RAM aligner.
package dwsa_pkg;

   localparam int ADDR_W  = 19;   // byte address width
   localparam int LEN_W   = 16;   // operation length width
   localparam int BYTE_W  = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_W  = WORD_BYTES * BYTE_W;

   localparam int DEF_LINE_BYTES     = 128;
   localparam int DEF_SEGMENTS       = 8;
   localparam int DEF_LINE_ADDR_BITS = 12;

   // closed beats waiting between front and back
   localparam int BEAT_QUEUE_DEPTH = 2;

endpackage

@@ hdl/dma_write_segmented_ram_aligner.sv @@
// DMA write byte-lane aligner for a segmented line RAM. Takes one request byte
// per cycle while full is low; the first byte of an operation carries its start
// address and length. Bytes are merged into their lanes of a LINE_BYTES wide
// line (a power of two) with per-byte enables and a per-segment valid mask. A
// beat closes at the end of a line, of the operation or of the address space
// and is then delivered as LINE_BYTES/8 responses, one 64-bit word each, word 0
// first. Lanes not written in a beat carry the line's earlier contents. A new
// start abandons an open beat without delivering it. Rate: requests are taken
// one per cycle while full is low; each closed beat occupies the response side
// for LINE_BYTES/8 pops (16 at the default size). Up to two closed beats wait
// between the two sides; full rises while both wait, so operations shorter than
// a line are held back by the one-word-per-pop response port.
module dma_write_segmented_ram_aligner
   import dwsa_pkg::*;
#(
   parameter int LINE_BYTES     = DEF_LINE_BYTES,
   parameter int SEGMENTS       = DEF_SEGMENTS,
   parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS,
   localparam int WORDS = LINE_BYTES / WORD_BYTES,
   localparam int IDX_W = $clog2(WORDS)
) (
   input  logic                      clock,
   input  logic                      reset,
   // request side
   input  logic                      push,
   output logic                      full,
   input  logic                      req_start_op,
   input  logic [ADDR_W-1:0]         req_start_addr,
   input  logic [LEN_W-1:0]          req_op_len,
   input  logic [BYTE_W-1:0]         req_data_byte,
   // response side
   output logic                      empty,
   input  logic                      pop,
   output logic [IDX_W-1:0]          rsp_word_index,
   output logic [WORD_W-1:0]         rsp_word_data,
   output logic [WORD_BYTES-1:0]     rsp_byte_enable,
   output logic [SEGMENTS-1:0]       rsp_seg_valid,
   output logic [LINE_ADDR_BITS-1:0] rsp_line_addr,
   output logic                      rsp_beat_last,
   output logic                      rsp_op_done
);

   localparam int LINE_W = WORDS * WORD_W;
   localparam int EN_W   = WORDS * WORD_BYTES;
   localparam int BEAT_W = LINE_W + EN_W + SEGMENTS + LINE_ADDR_BITS + 1;

   logic                             accept;
   logic                             beat_push;
   logic [WORDS-1:0][WORD_W-1:0]     beat_line;
   logic [WORDS-1:0][WORD_BYTES-1:0] beat_en;
   logic [SEGMENTS-1:0]              beat_seg;
   logic [LINE_ADDR_BITS-1:0]        beat_line_addr;
   logic                             beat_done;
   logic [BEAT_W-1:0]                beat_flat;
   logic [BEAT_W-1:0]                head_flat;
   logic                             q_full;
   logic                             q_empty;
   logic                             q_pop;

   // Hold requests only while both beat slots are taken.
   assign full   = q_full;
   assign accept = push && !q_full;

   dwsa_front #(
      .LINE_BYTES     (LINE_BYTES),
      .SEGMENTS       (SEGMENTS),
      .LINE_ADDR_BITS (LINE_ADDR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept_i         (accept),
      .start_op_i       (req_start_op),
      .start_addr_i     (req_start_addr),
      .op_len_i         (req_op_len),
      .data_byte_i      (req_data_byte),
      .beat_push_o      (beat_push),
      .beat_line_o      (beat_line),
      .beat_en_o        (beat_en),
      .beat_seg_o       (beat_seg),
      .beat_line_addr_o (beat_line_addr),
      .beat_done_o      (beat_done)
   );

   // Pack a closed beat: done flag on top, line data at the bottom.
   assign beat_flat = {beat_done, beat_line_addr, beat_seg, beat_en, beat_line};

   dwsa_beat_queue #(
      .WIDTH (BEAT_W),
      .DEPTH (BEAT_QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (beat_push),
      .data_i  (beat_flat),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .empty_o (q_empty),
      .head_o  (head_flat)
   );

   // Advance through the head beat word by word; drop it after its last word.
   dwsa_back #(
      .LINE_BYTES     (LINE_BYTES),
      .SEGMENTS       (SEGMENTS),
      .LINE_ADDR_BITS (LINE_ADDR_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty_i        (q_empty),
      .q_pop_o          (q_pop),
      .head_line_i      (head_flat[LINE_W-1:0]),
      .head_en_i        (head_flat[LINE_W +: EN_W]),
      .head_seg_i       (head_flat[LINE_W + EN_W +: SEGMENTS]),
      .head_line_addr_i (head_flat[LINE_W + EN_W + SEGMENTS +: LINE_ADDR_BITS]),
      .head_done_i      (head_flat[BEAT_W-1]),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_word_index   (rsp_word_index),
      .rsp_word_data    (rsp_word_data),
      .rsp_byte_enable  (rsp_byte_enable),
      .rsp_seg_valid    (rsp_seg_valid),
      .rsp_line_addr    (rsp_line_addr),
      .rsp_beat_last    (rsp_beat_last),
      .rsp_op_done      (rsp_op_done)
   );

endmodule

@@ hdl/dwsa_front.sv @@
// Front end: accepts request bytes, merges them into the line and closes beats.
module dwsa_front
   import dwsa_pkg::*;
#(
   parameter int LINE_BYTES     = DEF_LINE_BYTES,
   parameter int SEGMENTS       = DEF_SEGMENTS,
   parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS,
   localparam int WORDS = LINE_BYTES / WORD_BYTES,
   localparam int IDX_W = $clog2(WORDS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept_i,
   input  logic                               start_op_i,
   input  logic [ADDR_W-1:0]                  start_addr_i,
   input  logic [LEN_W-1:0]                   op_len_i,
   input  logic [BYTE_W-1:0]                  data_byte_i,
   output logic                               beat_push_o,
   output logic [WORDS-1:0][WORD_W-1:0]       beat_line_o,
   output logic [WORDS-1:0][WORD_BYTES-1:0]   beat_en_o,
   output logic [SEGMENTS-1:0]                beat_seg_o,
   output logic [LINE_ADDR_BITS-1:0]          beat_line_addr_o,
   output logic                               beat_done_o
);

   localparam int OFF_W     = $clog2(LINE_BYTES);
   localparam int SEG_BYTES = LINE_BYTES / SEGMENTS;

   logic [WORDS-1:0][WORD_W-1:0]     line_ff, line_in;
   logic [WORDS-1:0][WORD_BYTES-1:0] en_ff, en_in;
   logic [SEGMENTS-1:0]              seg_ff, seg_in;
   logic [ADDR_W-1:0]                next_addr_ff, next_addr_in;
   logic [LEN_W-1:0]                 left_ff, left_in;

   logic [ADDR_W-1:0]                eff_addr;
   logic [LEN_W-1:0]                 eff_left;
   logic [OFF_W-1:0]                 off;
   logic [IDX_W-1:0]                 word_sel;
   logic [2:0]                       lane;
   logic [ADDR_W+LINE_ADDR_BITS-1:0] addr_ext;
   logic [WORDS-1:0][WORD_W-1:0]     line_wr;
   logic [WORDS-1:0][WORD_BYTES-1:0] en_wr;
   logic [SEGMENTS-1:0]              seg_wr;
   logic                             done;
   logic                             close;

   assign eff_addr = start_op_i ? start_addr_i : next_addr_ff;
   assign eff_left = start_op_i ? op_len_i : left_ff;
   assign off      = eff_addr[OFF_W-1:0];
   assign word_sel = off[OFF_W-1:3];
   assign lane     = off[2:0];
   assign addr_ext = {{LINE_ADDR_BITS{1'b0}}, eff_addr} >> OFF_W;
   assign done     = (eff_left == LEN_W'(1));
   assign close    = done || (off == OFF_W'(LINE_BYTES - 1))
                   || (eff_addr == {ADDR_W{1'b1}});

   always_comb begin
      line_wr = line_ff;
      en_wr   = start_op_i ? '0 : en_ff;
      seg_wr  = start_op_i ? '0 : seg_ff;
      line_wr[word_sel][{lane, 3'b000} +: BYTE_W] = data_byte_i;
      en_wr[word_sel][lane] = 1'b1;
      for (int s = 0; s < SEGMENTS; s++) begin
         if (int'(off) >= s * SEG_BYTES && int'(off) < (s + 1) * SEG_BYTES) begin
            seg_wr[s] = 1'b1;
         end
      end
   end

   always_comb begin
      line_in      = line_ff;
      en_in        = en_ff;
      seg_in       = seg_ff;
      next_addr_in = next_addr_ff;
      left_in      = left_ff;
      beat_push_o  = 1'b0;
      if (accept_i) begin
         // a new start abandons any open beat
         if (start_op_i) begin
            en_in        = '0;
            seg_in       = '0;
            next_addr_in = start_addr_i;
            left_in      = op_len_i;
         end
         if (eff_left != '0) begin
            line_in      = line_wr;
            next_addr_in = eff_addr + ADDR_W'(1);
            left_in      = eff_left - LEN_W'(1);
            if (close) begin
               beat_push_o = 1'b1;
               en_in       = '0;
               seg_in      = '0;
            end else begin
               en_in  = en_wr;
               seg_in = seg_wr;
            end
         end
      end
   end

   assign beat_line_o      = line_wr;
   assign beat_en_o        = en_wr;
   assign beat_seg_o       = seg_wr;
   assign beat_line_addr_o = addr_ext[LINE_ADDR_BITS-1:0];
   assign beat_done_o      = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         en_ff        <= '0;
         seg_ff       <= '0;
         next_addr_ff <= '0;
         left_ff      <= '0;
      end else begin
         line_ff      <= line_in;
         en_ff        <= en_in;
         seg_ff       <= seg_in;
         next_addr_ff <= next_addr_in;
         left_ff      <= left_in;
      end
   end

endmodule

@@ hdl/dwsa_beat_queue.sv @@
// Short queue of closed beats between the front and back ends.
module dwsa_beat_queue
   import dwsa_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = BEAT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] data_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic             empty_o,
   output logic [WIDTH-1:0] head_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full_o |-> !push_i)
      else $error("beat pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty_o |-> !pop_i)
      else $error("beat popped from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not rise on push");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop_i && !push_i) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count did not fall on pop");
`endif

endmodule

@@ hdl/dwsa_back.sv @@
// Back end: drains the oldest closed beat one 64-bit word per pop.
module dwsa_back
   import dwsa_pkg::*;
#(
   parameter int LINE_BYTES     = DEF_LINE_BYTES,
   parameter int SEGMENTS       = DEF_SEGMENTS,
   parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS,
   localparam int WORDS = LINE_BYTES / WORD_BYTES,
   localparam int IDX_W = $clog2(WORDS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty_i,
   output logic                             q_pop_o,
   input  logic [WORDS-1:0][WORD_W-1:0]     head_line_i,
   input  logic [WORDS-1:0][WORD_BYTES-1:0] head_en_i,
   input  logic [SEGMENTS-1:0]              head_seg_i,
   input  logic [LINE_ADDR_BITS-1:0]        head_line_addr_i,
   input  logic                             head_done_i,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [IDX_W-1:0]                 rsp_word_index,
   output logic [WORD_W-1:0]                rsp_word_data,
   output logic [WORD_BYTES-1:0]            rsp_byte_enable,
   output logic [SEGMENTS-1:0]              rsp_seg_valid,
   output logic [LINE_ADDR_BITS-1:0]        rsp_line_addr,
   output logic                             rsp_beat_last,
   output logic                             rsp_op_done
);

   logic [IDX_W-1:0] word_cnt_ff, word_cnt_in;
   logic             take;

   assign take    = rsp_pop && !q_empty_i;
   assign q_pop_o = take && rsp_beat_last;

   always_comb begin
      word_cnt_in = word_cnt_ff;
      if (take) begin
         word_cnt_in = rsp_beat_last ? '0 : word_cnt_ff + IDX_W'(1);
      end
   end

   assign rsp_empty       = q_empty_i;
   assign rsp_word_index  = word_cnt_ff;
   assign rsp_word_data   = head_line_i[word_cnt_ff];
   assign rsp_byte_enable = head_en_i[word_cnt_ff];
   assign rsp_seg_valid   = head_seg_i;
   assign rsp_line_addr   = head_line_addr_i;
   assign rsp_beat_last   = (word_cnt_ff == IDX_W'(WORDS - 1));
   assign rsp_op_done     = head_done_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff <= '0;
      end else begin
         word_cnt_ff <= word_cnt_in;
      end
   end

endmodule
